FILE: sv/sfcr_pkg.sv
package sfcr_pkg;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SHORT  = 2'd1;
    localparam logic [1:0] PH_LONG   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_SUM = 2'd2;

    localparam logic [7:0]  LEN_SHORT  = 8'd7;
    localparam logic [7:0]  LEN_LONG   = 8'd8;
    localparam logic [2:0]  IDX_LENGTH = 3'd4;
    localparam logic [31:0] SYNC_RESET = 32'h1ACF_FC1D;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] command;
        logic [7:0] argument;
        logic       has_argument;
    } result_t;

endpackage

FILE: sv/sfcr_frame.sv
module sfcr_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          sync_word,
    input  logic [7:0]           rx_byte,
    input  logic                 advance,
    output logic                 emit,
    output sfcr_pkg::result_t    result
);

    logic [1:0] phase_reg, phase_next;
    logic [2:0] idx_reg, idx_next;
    logic       match_reg, match_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] arg_reg, arg_next;
    logic [7:0] expect_byte;
    logic       restart;

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    expect_byte = sync_word[31:24];
            2'd1:    expect_byte = sync_word[23:16];
            2'd2:    expect_byte = sync_word[15:8];
            default: expect_byte = sync_word[7:0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        match_next = match_reg;
        xor_next   = xor_reg;
        cmd_next   = cmd_reg;
        arg_next   = arg_reg;
        restart    = 1'b0;
        emit       = 1'b0;
        result     = '0;
        case (phase_reg)
            sfcr_pkg::PH_SHORT:
            begin
                if (idx_reg == 3'd0)
                begin
                    cmd_next = rx_byte;
                    xor_next = xor_reg ^ rx_byte;
                    idx_next = 3'd1;
                end
                else
                begin
                    restart = 1'b1;
                    emit    = 1'b1;
                    if (rx_byte == xor_reg)
                    begin
                        result.status  = sfcr_pkg::ST_OK;
                        result.command = cmd_reg;
                    end
                    else
                        result.status = sfcr_pkg::ST_BAD_SUM;
                end
            end
            sfcr_pkg::PH_LONG:
            begin
                if (idx_reg == 3'd0)
                begin
                    cmd_next = rx_byte;
                    xor_next = xor_reg ^ rx_byte;
                    idx_next = 3'd1;
                end
                else if (idx_reg == 3'd1)
                begin
                    arg_next = rx_byte;
                    xor_next = xor_reg ^ rx_byte;
                    idx_next = 3'd2;
                end
                else
                begin
                    restart = 1'b1;
                    emit    = 1'b1;
                    if (rx_byte == xor_reg)
                    begin
                        result.status       = sfcr_pkg::ST_OK;
                        result.command      = cmd_reg;
                        result.argument     = arg_reg;
                        result.has_argument = 1'b1;
                    end
                    else
                        result.status = sfcr_pkg::ST_BAD_SUM;
                end
            end
            default:
            begin
                if (idx_reg < sfcr_pkg::IDX_LENGTH)
                begin
                    if (rx_byte != expect_byte)
                        match_next = 1'b0;
                    xor_next   = xor_reg ^ rx_byte;
                    idx_next   = idx_reg + 3'd1;
                    phase_next = sfcr_pkg::PH_HEADER;
                end
                else if (!match_reg)
                    restart = 1'b1;
                else if (rx_byte == sfcr_pkg::LEN_SHORT || rx_byte == sfcr_pkg::LEN_LONG)
                begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = (rx_byte == sfcr_pkg::LEN_SHORT) ?
                                 sfcr_pkg::PH_SHORT : sfcr_pkg::PH_LONG;
                    idx_next   = 3'd0;
                end
                else
                begin
                    restart       = 1'b1;
                    emit          = 1'b1;
                    result.status = sfcr_pkg::ST_BAD_LEN;
                end
            end
        endcase
        if (restart)
        begin
            phase_next = sfcr_pkg::PH_HEADER;
            idx_next   = 3'd0;
            match_next = 1'b1;
            xor_next   = 8'd0;
            cmd_next   = 8'd0;
            arg_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfcr_pkg::PH_HEADER;
            idx_reg   <= 3'd0;
            match_reg <= 1'b1;
            xor_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            arg_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            match_reg <= match_next;
            xor_reg   <= xor_next;
            cmd_reg   <= cmd_next;
            arg_reg   <= arg_next;
        end
    end

endmodule

FILE: sv/sfcr_out_reg.sv
module sfcr_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  sfcr_pkg::result_t    result,
    input  logic                 out_stall,
    output logic                 ready,
    output logic                 out_valid,
    output sfcr_pkg::result_t    data
);

    logic              valid_reg;
    sfcr_pkg::result_t data_reg;

    assign ready     = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign data      = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

endmodule

FILE: sv/sync_framed_command_receiver.sv
// Sync-word framed command receiver, XOR checksum.
// A frame's last byte goes through the input register, then the result register.
// Throughput: one byte per cycle while in_stall is low; an input register and the
// result register let one byte enter while a result is held by out_stall.
// Reset (rst_n, async low): header search restarts, sync_word = 0x1ACFFC1D.
module sync_framed_command_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  command,
    output logic [7:0]  argument,
    output logic        has_argument
);

    logic [31:0]       sync_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              accept;
    logic              advance;
    logic              emit;
    logic              out_ready;
    sfcr_pkg::result_t frame_result;
    sfcr_pkg::result_t out_data;

    assign advance  = in_valid_reg && (!emit || out_ready);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg     <= sfcr_pkg::SYNC_RESET;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                sync_reg <= cfg_data;
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= rx_byte;
    end

    sfcr_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .sync_word (sync_reg),
        .rx_byte   (in_byte_reg),
        .advance   (advance),
        .emit      (emit),
        .result    (frame_result)
    );

    sfcr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .result    (frame_result),
        .out_stall (out_stall),
        .ready     (out_ready),
        .out_valid (out_valid),
        .data      (out_data)
    );

    assign status       = out_data.status;
    assign command      = out_data.command;
    assign argument     = out_data.argument;
    assign has_argument = out_data.has_argument;

endmodule

FILE: bench/sync_framed_command_receiver_test.sv
module sync_framed_command_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  command;
    logic [7:0]  argument;
    logic        has_argument;

    int send_idle_pct;
    int stall_pct;
    int holdoff_len;
    int bytes_sent;
    int error_count;
    int quiet_cycles;

    // framer shadow state
    logic [31:0] mdl_sync;
    logic [1:0]  mdl_phase;
    logic [2:0]  mdl_index;
    logic        mdl_sync_ok;
    logic [7:0]  mdl_xor;
    logic [7:0]  mdl_cmd;
    logic [7:0]  mdl_arg;

    sfcr_pkg::result_t frame_verdicts[$];
    sfcr_pkg::result_t seen_verdict;
    sfcr_pkg::result_t want_verdict;

    sync_framed_command_receiver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .command      (command),
        .argument     (argument),
        .has_argument (has_argument)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic restart_framer();
        mdl_phase   = sfcr_pkg::PH_HEADER;
        mdl_index   = '0;
        mdl_sync_ok = 1'b1;
        mdl_xor     = '0;
        mdl_cmd     = '0;
        mdl_arg     = '0;
    endtask

    task automatic push_verdict(input logic [1:0] st, input logic [7:0] cmd,
                                input logic [7:0] arg, input logic has);
        sfcr_pkg::result_t r;
        r.status       = st;
        r.command      = cmd;
        r.argument     = arg;
        r.has_argument = has;
        frame_verdicts.push_back(r);
    endtask

    task automatic advance_framer(input logic [7:0] b);
        logic [7:0] sync_byte;
        logic [7:0] cmd;
        logic [7:0] arg;
        if (mdl_phase == sfcr_pkg::PH_SHORT)
        begin
            if (mdl_index == 3'd0)
            begin
                mdl_cmd   = b;
                mdl_xor  ^= b;
                mdl_index = 3'd1;
            end
            else
            begin
                cmd = mdl_cmd;
                if (b == mdl_xor)
                    push_verdict(sfcr_pkg::ST_OK, cmd, 8'h00, 1'b0);
                else
                    push_verdict(sfcr_pkg::ST_BAD_SUM, 8'h00, 8'h00, 1'b0);
                restart_framer();
            end
        end
        else if (mdl_phase == sfcr_pkg::PH_LONG)
        begin
            if (mdl_index == 3'd0)
            begin
                mdl_cmd   = b;
                mdl_xor  ^= b;
                mdl_index = 3'd1;
            end
            else if (mdl_index == 3'd1)
            begin
                mdl_arg   = b;
                mdl_xor  ^= b;
                mdl_index = 3'd2;
            end
            else
            begin
                cmd = mdl_cmd;
                arg = mdl_arg;
                if (b == mdl_xor)
                    push_verdict(sfcr_pkg::ST_OK, cmd, arg, 1'b1);
                else
                    push_verdict(sfcr_pkg::ST_BAD_SUM, 8'h00, 8'h00, 1'b0);
                restart_framer();
            end
        end
        else if (mdl_index < sfcr_pkg::IDX_LENGTH)
        begin
            sync_byte = 8'(mdl_sync >> (24 - 8 * int'(mdl_index)));
            if (b != sync_byte)
                mdl_sync_ok = 1'b0;
            mdl_xor  ^= b;
            mdl_index = mdl_index + 3'd1;
            mdl_phase = sfcr_pkg::PH_HEADER;
        end
        else if (!mdl_sync_ok)
            restart_framer();
        else if (b == sfcr_pkg::LEN_SHORT || b == sfcr_pkg::LEN_LONG)
        begin
            mdl_xor  ^= b;
            mdl_phase = (b == sfcr_pkg::LEN_SHORT) ? sfcr_pkg::PH_SHORT : sfcr_pkg::PH_LONG;
            mdl_index = '0;
        end
        else
        begin
            restart_framer();
            push_verdict(sfcr_pkg::ST_BAD_LEN, 8'h00, 8'h00, 1'b0);
        end
    endtask

    // called at a rising edge, returns at the edge where the transaction is taken
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        bytes_sent++;
        advance_framer(b);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (frame_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync(input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        mdl_sync = value;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                              input logic [7:0] arg, input logic [7:0] sum_flip);
        logic [7:0] sum;
        sum = '0;
        for (int i = 3; i >= 0; i--)
        begin
            sum ^= mdl_sync[8*i +: 8];
            send_byte(mdl_sync[8*i +: 8]);
        end
        sum ^= len;
        send_byte(len);
        if (len == sfcr_pkg::LEN_SHORT || len == sfcr_pkg::LEN_LONG)
        begin
            sum ^= cmd;
            send_byte(cmd);
            if (len == sfcr_pkg::LEN_LONG)
            begin
                sum ^= arg;
                send_byte(arg);
            end
            send_byte(sum ^ sum_flip);
        end
    endtask

    task automatic send_bad_sync(input int pos, input logic [7:0] mask,
                                 input logic [7:0] tail);
        for (int i = 0; i < 4; i++)
            send_byte(mdl_sync[8*(3-i) +: 8] ^ ((i == pos) ? mask : 8'h00));
        send_byte(tail);
    endtask

    task automatic align_to_header();
        while (!(mdl_phase == sfcr_pkg::PH_HEADER && mdl_index == 3'd0))
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_random_frame();
        int roll;
        logic [7:0] len;
        roll = $urandom_range(99);
        len  = $urandom_range(1) ? sfcr_pkg::LEN_LONG : sfcr_pkg::LEN_SHORT;
        if (roll < 90)
            align_to_header();
        if (roll < 62)
            send_frame(len, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'h00);
        else if (roll < 74)
            send_frame(len, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(1, 255)));
        else if (roll < 82)
        begin
            len = 8'($urandom_range(255));
            if (len == sfcr_pkg::LEN_SHORT || len == sfcr_pkg::LEN_LONG)
                len = ~len;
            send_frame(len, 8'h00, 8'h00, 8'h00);
        end
        else if (roll < 90)
            send_bad_sync($urandom_range(3), 8'($urandom_range(1, 255)),
                          8'($urandom_range(255)));
        else
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_frame(sfcr_pkg::LEN_SHORT, 8'hFF, 8'h00, 8'h00);
        send_frame(sfcr_pkg::LEN_LONG, 8'h00, 8'hFF, 8'h80);
        send_frame(8'h00, 8'h00, 8'h00, 8'h00);
        send_bad_sync(0, 8'hFF, sfcr_pkg::LEN_LONG);
        settle();
    endtask

    task automatic test_sync_register();
        logic [31:0] patterns[4];
        logic [31:0] fresh;
        logic [7:0]  cmd;
        logic [7:0]  sum;
        patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), sfcr_pkg::SYNC_RESET};
        send_idle_pct = 10;
        stall_pct     = 10;
        foreach (patterns[i])
        begin
            write_sync(patterns[i]);
            repeat (4) send_random_frame();
            settle();
        end
        // earlier header bytes are judged against the old word
        align_to_header();
        send_byte(mdl_sync[31:24]);
        send_byte(mdl_sync[23:16]);
        sum = mdl_sync[31:24] ^ mdl_sync[23:16];
        settle();
        fresh = $urandom;
        write_sync(fresh);
        cmd = 8'($urandom_range(255));
        send_byte(fresh[15:8]);
        send_byte(fresh[7:0]);
        send_byte(sfcr_pkg::LEN_SHORT);
        send_byte(cmd);
        send_byte(sum ^ fresh[15:8] ^ fresh[7:0] ^ sfcr_pkg::LEN_SHORT ^ cmd);
        settle();
    endtask

    task automatic test_random_traffic(input int budget, input int send_pct,
                                       input int stall_value);
        int start;
        start         = bytes_sent;
        send_idle_pct = send_pct;
        stall_pct     = stall_value;
        while (bytes_sent - start < budget)
            send_random_frame();
        settle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        holdoff_len   = HOLDOFF_CYCLES;
        repeat (6)
        begin
            align_to_header();
            send_frame(sfcr_pkg::LEN_LONG, 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'h00);
        end
        settle();
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (holdoff_len) @(posedge clk);
                holdoff_len = 0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_verdict = {status, command, argument, has_argument};
            if (frame_verdicts.size() == 0)
                report_mismatch($sformatf("unexpected result status=%0d cmd=%h arg=%h has=%b",
                                          status, command, argument, has_argument));
            else
            begin
                want_verdict = frame_verdicts.pop_front();
                if (seen_verdict.status !== want_verdict.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              seen_verdict.status, want_verdict.status));
                if (seen_verdict.command !== want_verdict.command)
                    report_mismatch($sformatf("command %h, expected %h",
                                              seen_verdict.command, want_verdict.command));
                if (seen_verdict.argument !== want_verdict.argument)
                    report_mismatch($sformatf("argument %h, expected %h",
                                              seen_verdict.argument, want_verdict.argument));
                if (seen_verdict.has_argument !== want_verdict.has_argument)
                    report_mismatch($sformatf("has_argument %b, expected %b",
                                              seen_verdict.has_argument,
                                              want_verdict.has_argument));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR @%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        mdl_sync  = sfcr_pkg::SYNC_RESET;
        restart_framer();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_sync_register();
        test_random_traffic(280, 0, 0);
        test_random_traffic(280, 88, 0);
        test_random_traffic(280, 0, 88);
        test_random_traffic(280, 21, 21);
        test_backpressure();
        repeat (END_CYCLES) @(posedge clk);
        if (frame_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", frame_verdicts.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
